// File: rtl/avt_pkg.sv
// Shared types, constants and helper functions of the affine vertex transform.
// Used by every module under rtl; depends on nothing else.
package avt_pkg;

	localparam int WORD_BITS = 16;
	localparam int FRAC_BITS = 8;

	localparam int ENTRY_W = 16;
	localparam int MAT_DIM = 4;
	localparam int MAT_ENTRIES = MAT_DIM * MAT_DIM;
	localparam int INDEX_W = $clog2(MAT_ENTRIES);
	localparam int PROD_W = 2 * ENTRY_W;

	localparam int A41 = 12;
	localparam int A42 = 13;
	localparam int A43 = 14;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_XFORM = 1'b1;

	localparam logic [ENTRY_W-1:0] ENTRY_ONE = ENTRY_W'(64'd1 << FRAC_BITS);

	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [MAT_ENTRIES-1:0][ENTRY_W-1:0] matrix_t;

	typedef struct packed {
		logic load;
		logic point;
	} lane_ctl_t;

	function automatic matrix_t identity_matrix();
		matrix_t m;
		m = '0;
		for (int r = 0; r < MAT_DIM; r++) begin
			m[r * MAT_DIM + r] = ENTRY_ONE;
		end
		return m;
	endfunction

	function automatic entry_t word_to_entry(input word_t w);
		logic signed [31:0] wide;
		wide = 32'(w);
		return entry_t'(wide[ENTRY_W-1:0]);
	endfunction

endpackage

// File: rtl/avt_matrix.sv
// Register file holding the 4x4 matrix in row-major order, reset to identity.
// One write port; every entry is visible at once. Depends on avt_pkg.
module avt_matrix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [avt_pkg::INDEX_W-1:0] wr_index,
	input  logic [avt_pkg::ENTRY_W-1:0] wr_value,
	output avt_pkg::matrix_t            entries
);

	avt_pkg::matrix_t mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= avt_pkg::identity_matrix();
		end else if (wr_en) begin
			mat_q[wr_index] <= wr_value;
		end
	end

	assign entries = mat_q;

endmodule

// File: rtl/avt_lane.sv
// One output column: three fixed-point products registered in stage one,
// then the wrapping sum with the optional translation term. Depends on avt_pkg.
module avt_lane (
	input  logic                 clk,
	input  avt_pkg::lane_ctl_t   ctl,
	input  avt_pkg::entry_t      vec_x,
	input  avt_pkg::entry_t      vec_y,
	input  avt_pkg::entry_t      vec_z,
	input  avt_pkg::entry_t      m_x,
	input  avt_pkg::entry_t      m_y,
	input  avt_pkg::entry_t      m_z,
	input  avt_pkg::entry_t      m_t,
	output avt_pkg::entry_t      sum
);

	logic signed [avt_pkg::PROD_W-1:0] prod_x, prod_y, prod_z;
	avt_pkg::word_t term_x_s1, term_y_s1, term_z_s1, term_t_s1;
	avt_pkg::word_t total;

	assign prod_x = vec_x * m_x;
	assign prod_y = vec_y * m_y;
	assign prod_z = vec_z * m_z;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			term_x_s1 <= avt_pkg::WORD_BITS'(prod_x >>> avt_pkg::FRAC_BITS);
			term_y_s1 <= avt_pkg::WORD_BITS'(prod_y >>> avt_pkg::FRAC_BITS);
			term_z_s1 <= avt_pkg::WORD_BITS'(prod_z >>> avt_pkg::FRAC_BITS);
			term_t_s1 <= ctl.point ? avt_pkg::WORD_BITS'(32'(m_t)) : '0;
		end
	end

	assign total = term_x_s1 + term_y_s1 + term_z_s1 + term_t_s1;
	assign sum = avt_pkg::word_to_entry(total);

endmodule

// File: rtl/avt_merge.sv
// Output register that gathers the three lane sums into one result word.
// Holds the word until it is taken. Depends on avt_pkg.
module avt_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            lanes_valid,
	output logic            take,
	input  avt_pkg::entry_t sum_x,
	input  avt_pkg::entry_t sum_y,
	input  avt_pkg::entry_t sum_z,
	output logic            out_valid,
	input  logic            out_ready,
	output avt_pkg::entry_t out_x,
	output avt_pkg::entry_t out_y,
	output avt_pkg::entry_t out_z
);

	logic valid_q;
	avt_pkg::entry_t x_q, y_q, z_q;

	assign take = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= lanes_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && lanes_valid) begin
			x_q <= sum_x;
			y_q <= sum_y;
			z_q <= sum_z;
		end
	end

	assign out_valid = valid_q;
	assign out_x = x_q;
	assign out_y = y_q;
	assign out_z = z_q;

endmodule

// File: rtl/affine_vertex_transform.sv
// Top level of the affine vertex transform: matrix store, three column lanes
// and the output merge register. Depends on avt_pkg, avt_matrix, avt_lane, avt_merge.
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | req_type entry_index entry_value vec_x vec_y vec_z
//           |                      | is_direction
//   output  | out_valid/ out_ready | out_x out_y out_z
//
// One input word is taken every cycle while in_ready is high, writes and transforms alike.
// A transform word is registered first in the lane stage, where its products are held,
// then in the merge register; a stall at the output can hold it in the lane stage.
// A write updates the matrix at the edge it is taken and gives no output word.
// Reset loads the identity matrix at once; no clearing pass is needed.
// When the output stalls, words are still taken until a transform fills the lane stage.
module affine_vertex_transform (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [avt_pkg::INDEX_W-1:0] entry_index,
	input  avt_pkg::entry_t             entry_value,
	input  avt_pkg::entry_t             vec_x,
	input  avt_pkg::entry_t             vec_y,
	input  avt_pkg::entry_t             vec_z,
	input  logic                        is_direction,
	output logic                        out_valid,
	input  logic                        out_ready,
	output avt_pkg::entry_t             out_x,
	output avt_pkg::entry_t             out_y,
	output avt_pkg::entry_t             out_z
);

	avt_pkg::matrix_t   entries;
	avt_pkg::lane_ctl_t lane_ctl;
	avt_pkg::entry_t    sum_x, sum_y, sum_z;
	logic               valid_s1;
	logic               take;
	logic               advance;
	logic               in_fire;
	logic               wr_en;
	logic               xform_en;

	assign advance  = !valid_s1 || take;
	assign in_ready = advance;
	assign in_fire  = in_valid && in_ready;
	assign wr_en    = in_fire && (req_type == avt_pkg::REQ_WRITE);
	assign xform_en = in_fire && (req_type == avt_pkg::REQ_XFORM);

	assign lane_ctl.load  = xform_en;
	assign lane_ctl.point = !is_direction;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= xform_en;
		end
	end

	avt_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (entry_index),
		.wr_value (entry_value),
		.entries  (entries)
	);

	avt_lane u_lane_x (
		.clk   (clk),
		.ctl   (lane_ctl),
		.vec_x (vec_x),
		.vec_y (vec_y),
		.vec_z (vec_z),
		.m_x   (entries[avt_pkg::A41 - 12]),
		.m_y   (entries[avt_pkg::A41 - 12 + avt_pkg::MAT_DIM]),
		.m_z   (entries[avt_pkg::A41 - 12 + 2 * avt_pkg::MAT_DIM]),
		.m_t   (entries[avt_pkg::A41]),
		.sum   (sum_x)
	);

	avt_lane u_lane_y (
		.clk   (clk),
		.ctl   (lane_ctl),
		.vec_x (vec_x),
		.vec_y (vec_y),
		.vec_z (vec_z),
		.m_x   (entries[avt_pkg::A42 - 12]),
		.m_y   (entries[avt_pkg::A42 - 12 + avt_pkg::MAT_DIM]),
		.m_z   (entries[avt_pkg::A42 - 12 + 2 * avt_pkg::MAT_DIM]),
		.m_t   (entries[avt_pkg::A42]),
		.sum   (sum_y)
	);

	avt_lane u_lane_z (
		.clk   (clk),
		.ctl   (lane_ctl),
		.vec_x (vec_x),
		.vec_y (vec_y),
		.vec_z (vec_z),
		.m_x   (entries[avt_pkg::A43 - 12]),
		.m_y   (entries[avt_pkg::A43 - 12 + avt_pkg::MAT_DIM]),
		.m_z   (entries[avt_pkg::A43 - 12 + 2 * avt_pkg::MAT_DIM]),
		.m_t   (entries[avt_pkg::A43]),
		.sum   (sum_z)
	);

	avt_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.lanes_valid (valid_s1),
		.take        (take),
		.sum_x       (sum_x),
		.sum_y       (sum_y),
		.sum_z       (sum_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z)
	);

`ifndef SYNTHESIS
	a_xform_enters_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		xform_en |=> valid_s1)
		else $error("accepted transform word did not reach the lane stage");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !valid_s1) |=> !valid_s1)
		else $error("matrix write produced a lane result");

	a_lane_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take) |=> valid_s1)
		else $error("lane result dropped while the output stalled");

	a_lane_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && take) |=> out_valid)
		else $error("lane result did not reach the output register");
`endif

endmodule

// File: bench/affine_vertex_transform_check.sv
// Checker for the affine vertex transform: watches both channels and predicts each output word.
// Keeps its own copy of the matrix and compares the output words in order.
// Depends on avt_pkg for the widths, the constants and the entry type.
module affine_vertex_transform_check
	import avt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               req_type,
	input  logic [INDEX_W-1:0] entry_index,
	input  entry_t             entry_value,
	input  entry_t             vec_x,
	input  entry_t             vec_y,
	input  entry_t             vec_z,
	input  logic               is_direction,
	input  logic               out_valid,
	input  logic               out_ready,
	input  entry_t             out_x,
	input  entry_t             out_y,
	input  entry_t             out_z,
	output int                 errors,
	output int                 pending,
	output int                 checked,
	output int                 writes
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		entry_t x;
		entry_t y;
		entry_t z;
	} vertex_t;

	entry_t  shadow_matrix [MAT_ENTRIES];
	vertex_t expected_vertices [$];
	vertex_t oldest;

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	task automatic compare_field(input string name, input entry_t got, input entry_t want);
		if (got !== want) begin
			report($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// One output component: three scaled products, plus the translation row for a point.
	function automatic entry_t column_value(input entry_t vx, input entry_t vy, input entry_t vz,
			input int col, input logic point);
		logic signed [PROD_W-1:0] prod;
		logic signed [63:0] acc;
		word_t wrapped;
		longint widened;
		prod = vx * shadow_matrix[col];
		acc = prod >>> FRAC_BITS;
		prod = vy * shadow_matrix[MAT_DIM + col];
		acc = acc + (prod >>> FRAC_BITS);
		prod = vz * shadow_matrix[2 * MAT_DIM + col];
		acc = acc + (prod >>> FRAC_BITS);
		if (point) begin
			acc = acc + shadow_matrix[A41 + col];
		end
		wrapped = word_t'(acc);
		widened = wrapped;
		return entry_t'(widened);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_ENTRIES; i++) begin
				shadow_matrix[i] = '0;
			end
			for (int r = 0; r < MAT_DIM; r++) begin
				shadow_matrix[r * MAT_DIM + r] = entry_t'(64'd1 << FRAC_BITS);
			end
			expected_vertices.delete();
			errors = 0;
			checked = 0;
			writes = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_vertices.size() == 0) begin
					report($sformatf("output word (%0d, %0d, %0d) with nothing expected",
						out_x, out_y, out_z));
				end else begin
					oldest = expected_vertices.pop_front();
					compare_field("out_x", out_x, oldest.x);
					compare_field("out_y", out_y, oldest.y);
					compare_field("out_z", out_z, oldest.z);
					checked++;
				end
			end
			if (in_valid && in_ready) begin
				if (req_type == REQ_WRITE) begin
					shadow_matrix[entry_index] = entry_value;
					writes++;
				end else begin
					expected_vertices.push_back('{
						x: column_value(vec_x, vec_y, vec_z, A41 - A41, !is_direction),
						y: column_value(vec_x, vec_y, vec_z, A42 - A41, !is_direction),
						z: column_value(vec_x, vec_y, vec_z, A43 - A41, !is_direction)});
				end
			end
		end
		pending = expected_vertices.size();
	end

endmodule

// File: bench/affine_vertex_transform_test.sv
// Top of the affine vertex transform bench: clock, reset, stimulus and the verdict.
// Instantiates affine_vertex_transform and affine_vertex_transform_check; depends on avt_pkg.
module affine_vertex_transform_test;
	timeunit 1ns;
	timeprecision 1ps;
	import avt_pkg::*;

	localparam int RANDOM_WORDS = 650;
	localparam int CYCLE_LIMIT = 120000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic [INDEX_W-1:0] entry_index;
	entry_t             entry_value;
	entry_t             vec_x;
	entry_t             vec_y;
	entry_t             vec_z;
	logic               is_direction;
	logic               out_valid;
	logic               out_ready;
	entry_t             out_x;
	entry_t             out_y;
	entry_t             out_z;

	int errors;
	int pending;
	int checked;
	int writes;
	int sent;
	int cycles;
	bit calm;
	int directed_words;

	affine_vertex_transform uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.vec_x        (vec_x),
		.vec_y        (vec_y),
		.vec_z        (vec_z),
		.is_direction (is_direction),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z)
	);

	affine_vertex_transform_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.vec_x        (vec_x),
		.vec_y        (vec_y),
		.vec_z        (vec_z),
		.is_direction (is_direction),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked),
		.writes       (writes)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("affine_vertex_transform regression: fail");
			$finish;
		end
	end

	function automatic entry_t rand_entry();
		case ($urandom_range(0, 7))
			0: return entry_t'(16'h8000);
			1: return entry_t'(16'h7fff);
			2: return $urandom_range(0, 1) ? entry_t'(-1) : entry_t'(0);
			3, 4: return entry_t'($urandom_range(0, 1023) - 512);
			default: return entry_t'($urandom);
		endcase
	endfunction

	task automatic send_word(input logic kind, input logic [INDEX_W-1:0] idx, input entry_t val,
			input entry_t x, input entry_t y, input entry_t z, input logic dir);
		in_valid <= 1'b1;
		req_type <= kind;
		entry_index <= idx;
		entry_value <= val;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		is_direction <= dir;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Vector fields of a write word carry random noise; the block must ignore them.
	task automatic write_entry(input int idx, input entry_t val);
		send_word(REQ_WRITE, idx[INDEX_W-1:0], val, entry_t'($urandom), entry_t'($urandom),
			entry_t'($urandom), 1'($urandom));
	endtask

	task automatic transform_vertex(input entry_t x, input entry_t y, input entry_t z,
			input logic dir);
		send_word(REQ_XFORM, INDEX_W'($urandom), entry_t'($urandom), x, y, z, dir);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		out_ready <= 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_WRITE;
		entry_index <= '0;
		entry_value <= '0;
		vec_x <= '0;
		vec_y <= '0;
		vec_z <= '0;
		is_direction <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		transform_vertex(16'sh7fff, 16'sh8000, 16'sh0000, 1'b0);
		transform_vertex(-16'sd1, 16'sd1, 16'sh8000, 1'b1);
		write_entry(A41, 16'sh7fff);
		write_entry(A42, 16'sh8000);
		write_entry(A43, -16'sd1);
		transform_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
		transform_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
		write_entry(0, 16'sh8000);
		write_entry(5, 16'sh7fff);
		write_entry(10, 16'sh8000);
		write_entry(3, 16'sh7fff);
		write_entry(7, 16'sh8000);
		write_entry(11, -16'sd1);
		write_entry(15, 16'sh7fff);
		write_entry(1, -16'sd1);
		write_entry(2, 16'sd384);
		write_entry(4, -16'sd200);
		write_entry(6, 16'sh7fff);
		write_entry(8, 16'sh8000);
		write_entry(9, 16'sd1);
		transform_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		transform_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1);
		transform_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0);
		transform_vertex(-16'sd1, -16'sd1, -16'sd1, 1'b0);
		in_valid <= 1'b0;
		wait_drained();
		directed_words = sent;

		while (sent < directed_words + RANDOM_WORDS) begin
			calm = (sent > directed_words + RANDOM_WORDS - 100)
				|| (sent > directed_words + 300 && sent < directed_words + 360);
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 1)) begin
							write_entry($urandom_range(0, MAT_ENTRIES - 1), rand_entry());
						end else begin
							transform_vertex(rand_entry(), rand_entry(), rand_entry(),
								1'($urandom));
						end
					end
				end
				default: begin
					repeat ($urandom_range(1, 6)) begin
						write_entry($urandom_range(0, MAT_ENTRIES - 1), rand_entry());
					end
					repeat ($urandom_range(2, 10)) begin
						transform_vertex(rand_entry(), rand_entry(), rand_entry(),
							1'($urandom));
					end
				end
			endcase
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d words: %0d matrix writes and %0d transformed vertices checked,",
			sent, writes, checked);
		$display("with extreme entries, points and directions, and stalls on both channels.");
		if (errors == 0 && pending == 0) begin
			$display("affine_vertex_transform regression: pass");
		end else begin
			$display("affine_vertex_transform regression: fail");
		end
		$finish;
	end

endmodule
